FILE: rtl/shp_pkg.sv
// ----------------------------------------------------------------------------
// Shor post-processing package
// Widths, register indexes, result codes, controller states and the command
// and status structures shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int MEAS_W     = 32;
  localparam int FULL_W     = 33;
  localparam int N_W        = 16;
  localparam int RB_W       = 5;
  localparam int EXP_W      = 17;
  localparam int LHS_W      = 50;
  localparam int DIV_W      = 33;
  localparam int ST_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COMPOSITE_N   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COPRIME_A     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_BITS = 2'd2;

  // Register values after reset.
  localparam logic [N_W-1:0]  COMPOSITE_N_RESET   = 16'd15;
  localparam logic [N_W-1:0]  COPRIME_A_RESET     = 16'd7;
  localparam logic [RB_W-1:0] REQUIRED_BITS_RESET = 5'd4;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_ODD       = 3'd3,
    ST_TRIVIAL   = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_CF_INIT,
    OP_DIV_EU,
    OP_EU_STEP,
    OP_MUL_QP,
    OP_SHIFT_CONV,
    OP_PS_INIT,
    OP_PS_NEXT,
    OP_PM_INIT,
    OP_PM_BASE,
    OP_PM_MUL,
    OP_PM_ACC,
    OP_PM_SQ,
    OP_PM_SQD,
    OP_G1_INIT,
    OP_G_DIV,
    OP_G_STEP,
    OP_G1_SAVE,
    OP_G2_SAVE,
    OP_RES
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ZERO,
    S_EU_DIV,
    S_EU_WAIT,
    S_TERM,
    S_QCHK,
    S_CLOSE,
    S_PM_INIT,
    S_PM_BASE,
    S_PM_BIT,
    S_PM_MULW,
    S_PM_SQ,
    S_PM_SQW,
    S_PM_DONE,
    S_G_CHK,
    S_G_WAIT,
    S_G_FIN,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t  op;
    logic    half;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic meas_zero;
    logic eu_end;
    logic div_done;
    logic term_big;
    logic q_big;
    logic close;
    logic ebits_zero;
    logic ebit0;
    logic pm_one;
    logic e_lt_n;
    logic e_odd;
    logic x_zero;
    logic g_trivial;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/shp_in_if.sv
// ----------------------------------------------------------------------------
// Measurement channel
// Valid/ready channel carrying one measured counting register value.
// ----------------------------------------------------------------------------
interface shp_in_if;
  logic                        valid;
  logic                        ready;
  logic [shp_pkg::MEAS_W-1:0]  measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

FILE: rtl/shp_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the two factors and the result status.
// ----------------------------------------------------------------------------
interface shp_out_if;
  logic                       valid;
  logic                       ready;
  logic [shp_pkg::N_W-1:0]    factor_one;
  logic [shp_pkg::N_W-1:0]    factor_two;
  logic [shp_pkg::ST_W-1:0]   status;

  modport source (output valid, output factor_one, output factor_two, output status,
                  input ready);
  modport sink   (input valid, input factor_one, input factor_two, input status,
                  output ready);
endinterface

FILE: rtl/shp_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle; quotient and remainder are valid
// when done pulses.
// ----------------------------------------------------------------------------
module shp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [shp_pkg::DIV_W-1:0]  dividend,
  input  logic [shp_pkg::DIV_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [shp_pkg::DIV_W-1:0]  quo,
  output logic [shp_pkg::DIV_W-1:0]  rem
);
  import shp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   part;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   shifted;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign shifted = {part[DIV_W-1:0], quo_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      part  <= '0;
      quo_r <= dividend;
      dsr   <= divisor;
    end else if (busy) begin
      part  <= ge ? (shifted - {1'b0, dsr}) : shifted;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign quo = quo_r;
  assign rem = part[DIV_W-1:0];

endmodule

FILE: rtl/shp_dp.sv
// ----------------------------------------------------------------------------
// Shor post-processing datapath
// Configuration registers, continued fraction and convergent registers,
// modular exponentiation and gcd registers around the shared divider, and
// the result register.
// ----------------------------------------------------------------------------
module shp_dp #(
  parameter int MAX_BITS  = 16,
  parameter int MAX_TERMS = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [shp_pkg::MEAS_W-1:0]      meas_in,
  input  shp_pkg::dp_cmd_t                cmd,
  output shp_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [shp_pkg::N_W-1:0]         factor_one,
  output logic [shp_pkg::N_W-1:0]         factor_two,
  output logic [shp_pkg::ST_W-1:0]        status
);
  import shp_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  // Configuration.
  logic [N_W-1:0]   modn;
  logic [N_W-1:0]   base_a;
  logic [RB_W-1:0]  req_bits;

  // Expansion and convergents.
  logic [MEAS_W-1:0] meas_r;
  logic [FULL_W-1:0] top_r;
  logic [FULL_W-1:0] bot_r;
  logic [CNT_W-1:0]  count_r;
  logic [FULL_W-1:0] term_r;
  logic [N_W-1:0]    qm1, qm2, pm1, pm2;
  logic [2*N_W-1:0]  qn, pn;
  logic [MEAS_W+N_W-1:0] lhs_r;

  // Period search, exponentiation and gcd.
  logic [EXP_W-1:0] e_r;
  logic [EXP_W-1:0] ebits;
  logic [N_W-1:0]   base_r;
  logic [N_W-1:0]   acc_r;
  logic [N_W-1:0]   h_r;
  logic [N_W-1:0]   gx, gy;
  logic [N_W-1:0]   g1_r, g2_r;

  // Divider connection.
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q, div_r;
  logic [N_W-1:0]   mul_x, mul_y;
  logic [2*N_W-1:0] mul_p;

  // Derived values.
  logic [RB_W-1:0]   rb_eff;
  logic [5:0]        sh2n;
  logic [FULL_W-1:0] full_w;
  logic [FULL_W-1:0] mask_w;
  logic [LHS_W-1:0]  lhs2, rhs, diff;
  logic [N_W:0]      h_inc;

  // Width is clamped to MAX_BITS; full is 2^(2n).
  assign rb_eff = (req_bits > RB_W'(MAX_BITS)) ? RB_W'(MAX_BITS) : req_bits;
  assign sh2n   = {rb_eff, 1'b0};
  assign full_w = FULL_W'(1) << sh2n;
  assign mask_w = full_w - FULL_W'(1);

  // Closeness: |2*m*q - 2*full*p| against q.
  assign lhs2 = {1'b0, lhs_r, 1'b0};
  assign rhs  = {{(LHS_W - N_W){1'b0}}, pm1} << (sh2n + 6'd1);
  assign diff = (lhs2 >= rhs) ? (lhs2 - rhs) : (rhs - lhs2);

  assign h_inc = {1'b0, h_r} + 1'b1;

  // Single 16x16 modular product feeding the divider.
  always_comb begin
    mul_x = acc_r;
    mul_y = base_r;
    if (cmd.op == OP_PM_SQ) begin
      mul_x = base_r;
    end
  end
  assign mul_p = mul_x * mul_y;

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_a     = top_r;
    div_b     = bot_r;
    case (cmd.op)
      OP_DIV_EU: begin
        div_start = 1'b1;
      end
      OP_PM_INIT: begin
        div_start = 1'b1;
        div_a     = {{(DIV_W - N_W){1'b0}}, base_a};
        div_b     = {{(DIV_W - N_W){1'b0}}, modn};
      end
      OP_PM_MUL, OP_PM_SQ: begin
        div_start = 1'b1;
        div_a     = {1'b0, mul_p};
        div_b     = {{(DIV_W - N_W){1'b0}}, modn};
      end
      OP_G_DIV: begin
        div_start = 1'b1;
        div_a     = {{(DIV_W - N_W){1'b0}}, gy};
        div_b     = {{(DIV_W - N_W){1'b0}}, gx};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  shp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modn     <= COMPOSITE_N_RESET;
      base_a   <= COPRIME_A_RESET;
      req_bits <= REQUIRED_BITS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMPOSITE_N:   modn     <= cfg_data;
        REG_COPRIME_A:     base_a   <= cfg_data;
        REG_REQUIRED_BITS: req_bits <= cfg_data[RB_W-1:0];
        default:           ;
      endcase
    end
  end

  // Working registers, updated by the command of each cycle.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        meas_r <= meas_in & mask_w[MEAS_W-1:0];
      end
      OP_CF_INIT: begin
        top_r   <= full_w;
        bot_r   <= {1'b0, meas_r};
        count_r <= '0;
        qm2     <= '0;
        qm1     <= N_W'(1);
        pm2     <= N_W'(1);
        pm1     <= '0;
      end
      OP_EU_STEP: begin
        term_r  <= div_q;
        top_r   <= bot_r;
        bot_r   <= div_r;
        count_r <= count_r + 1'b1;
      end
      OP_MUL_QP: begin
        qn <= term_r[N_W-1:0] * qm1 + {{N_W{1'b0}}, qm2};
        pn <= term_r[N_W-1:0] * pm1 + {{N_W{1'b0}}, pm2};
      end
      OP_SHIFT_CONV: begin
        lhs_r <= meas_r * qn[N_W-1:0];
        qm2   <= qm1;
        qm1   <= qn[N_W-1:0];
        pm2   <= pm1;
        pm1   <= pn[N_W-1:0];
      end
      OP_PS_INIT: begin
        e_r <= {1'b0, qm1};
      end
      OP_PS_NEXT: begin
        e_r <= e_r + {1'b0, qm1};
      end
      OP_PM_INIT: begin
        ebits <= cmd.half ? (e_r >> 1) : e_r;
        acc_r <= N_W'(1);
      end
      OP_PM_BASE: begin
        base_r <= div_r[N_W-1:0];
      end
      OP_PM_ACC: begin
        acc_r <= div_r[N_W-1:0];
      end
      OP_PM_SQD: begin
        base_r <= div_r[N_W-1:0];
        ebits  <= ebits >> 1;
      end
      OP_G1_INIT: begin
        h_r <= acc_r;
        gx  <= (acc_r == '0) ? (modn - 1'b1) : (acc_r - 1'b1);
        gy  <= modn;
      end
      OP_G_STEP: begin
        gy <= gx;
        gx <= div_r[N_W-1:0];
      end
      OP_G1_SAVE: begin
        g1_r <= gy;
        gx   <= (h_inc == {1'b0, modn}) ? '0 : h_inc[N_W-1:0];
        gy   <= modn;
      end
      OP_G2_SAVE: begin
        g2_r <= gy;
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_RES) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RES) begin
      status     <= cmd.code;
      factor_one <= (cmd.code == ST_OK) ? g1_r : '0;
      factor_two <= (cmd.code == ST_OK) ? g2_r : '0;
    end
  end

  // Status towards the controller.
  always_comb begin
    stat.meas_zero  = (meas_r == '0);
    stat.eu_end     = (bot_r == '0) || (count_r == CNT_W'(MAX_TERMS));
    stat.div_done   = div_done;
    stat.term_big   = term_r > {{(FULL_W - N_W){1'b0}}, modn};
    stat.q_big      = qn > {{N_W{1'b0}}, modn};
    stat.close      = diff < {{(LHS_W - N_W){1'b0}}, qm1};
    stat.ebits_zero = (ebits == '0);
    stat.ebit0      = ebits[0];
    stat.pm_one     = (acc_r == N_W'(1));
    stat.e_lt_n     = e_r < {1'b0, modn};
    stat.e_odd      = e_r[0];
    stat.x_zero     = (gx == '0);
    stat.g_trivial  = (g1_r == N_W'(1)) || (g2_r == N_W'(1));
    stat.out_busy   = out_valid && !out_ready;
  end

  // The divider is only started when it has finished its previous job.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // A result load always presents a result in the next cycle.
  a_res_shown: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_RES) |=> out_valid)
    else $error("result loaded but not presented");

  // Every accepted convergent has a non-zero denominator.
  a_denom_nz: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SHIFT_CONV) |=> (qm1 != '0))
    else $error("zero convergent denominator");

endmodule

FILE: rtl/shp_ctrl.sv
// ----------------------------------------------------------------------------
// Shor post-processing controller
// Sequences the continued fraction expansion, the closeness test, the
// period search by modular exponentiation and the two gcd computations.
// ----------------------------------------------------------------------------
module shp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  shp_pkg::dp_stat_t  stat,
  output shp_pkg::dp_cmd_t   cmd
);
  import shp_pkg::*;

  ctrl_state_t state, state_next;
  logic        half, half_next;
  logic        gsel, gsel_next;
  status_t     code, code_next;

  // State and context registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      half  <= 1'b0;
      gsel  <= 1'b0;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      half  <= half_next;
      gsel  <= gsel_next;
      code  <= code_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    half_next  = half;
    gsel_next  = gsel;
    code_next  = code;
    in_ready   = 1'b0;
    cmd.op     = OP_NOP;
    cmd.half   = half;
    cmd.code   = code;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        if (stat.meas_zero) begin
          code_next  = ST_ZERO;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_CF_INIT;
          state_next = S_EU_DIV;
        end
      end
      S_EU_DIV: begin
        if (stat.eu_end) begin
          code_next  = ST_NONE;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_DIV_EU;
          state_next = S_EU_WAIT;
        end
      end
      S_EU_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_EU_STEP;
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        if (stat.term_big) begin
          code_next  = ST_TOO_LARGE;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_MUL_QP;
          state_next = S_QCHK;
        end
      end
      S_QCHK: begin
        if (stat.q_big) begin
          code_next  = ST_TOO_LARGE;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_SHIFT_CONV;
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (stat.close) begin
          cmd.op     = OP_PS_INIT;
          half_next  = 1'b0;
          state_next = S_PM_INIT;
        end else begin
          state_next = S_EU_DIV;
        end
      end
      S_PM_INIT: begin
        cmd.op     = OP_PM_INIT;
        state_next = S_PM_BASE;
      end
      S_PM_BASE: begin
        if (stat.div_done) begin
          cmd.op     = OP_PM_BASE;
          state_next = S_PM_BIT;
        end
      end
      S_PM_BIT: begin
        if (stat.ebits_zero) begin
          state_next = S_PM_DONE;
        end else if (stat.ebit0) begin
          cmd.op     = OP_PM_MUL;
          state_next = S_PM_MULW;
        end else begin
          state_next = S_PM_SQ;
        end
      end
      S_PM_MULW: begin
        if (stat.div_done) begin
          cmd.op     = OP_PM_ACC;
          state_next = S_PM_SQ;
        end
      end
      S_PM_SQ: begin
        cmd.op     = OP_PM_SQ;
        state_next = S_PM_SQW;
      end
      S_PM_SQW: begin
        if (stat.div_done) begin
          cmd.op     = OP_PM_SQD;
          state_next = S_PM_BIT;
        end
      end
      S_PM_DONE: begin
        if (half) begin
          cmd.op     = OP_G1_INIT;
          gsel_next  = 1'b0;
          state_next = S_G_CHK;
        end else if (stat.pm_one) begin
          if (stat.e_odd) begin
            code_next  = ST_ODD;
            state_next = S_OUT;
          end else begin
            half_next  = 1'b1;
            state_next = S_PM_INIT;
          end
        end else if (stat.e_lt_n) begin
          cmd.op     = OP_PS_NEXT;
          state_next = S_PM_INIT;
        end else begin
          state_next = S_EU_DIV;
        end
      end
      S_G_CHK: begin
        if (!stat.x_zero) begin
          cmd.op     = OP_G_DIV;
          state_next = S_G_WAIT;
        end else if (!gsel) begin
          cmd.op     = OP_G1_SAVE;
          gsel_next  = 1'b1;
        end else begin
          cmd.op     = OP_G2_SAVE;
          state_next = S_G_FIN;
        end
      end
      S_G_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_G_STEP;
          state_next = S_G_CHK;
        end
      end
      S_G_FIN: begin
        code_next  = stat.g_trivial ? ST_TRIVIAL : ST_OK;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_RES;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/shor_period_post_processing_core.sv
// ----------------------------------------------------------------------------
// Shor period post-processing core
// Turns one measurement of the counting register into the two factors of N.
// ----------------------------------------------------------------------------
// One measurement is taken at a time and always gives exactly one result.
// The time per item depends on the data: every division is done on one
// shared restoring divider. The exponent of each modular exponentiation has
// at most 17 bits. The period search runs one exponentiation per tried
// multiple of the denominator, so the number of exponentiations grows with
// N / q. A new measurement is taken while the previous result still waits
// in the output register; a finished result waits until that register is
// free.
module shor_period_post_processing_core #(
  parameter int MAX_BITS  = 16,
  parameter int MAX_TERMS = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data,
  shp_in_if.sink                          measure,
  shp_out_if.source                       result
);
  import shp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  shp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (measure.valid),
    .in_ready (measure.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and result register.
  shp_dp #(
    .MAX_BITS  (MAX_BITS),
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .meas_in    (measure.measurement),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .factor_one (result.factor_one),
    .factor_two (result.factor_two),
    .status     (result.status)
  );

endmodule
